/* rtl/wrsi_pkg.sv */
package wrsi_pkg;

    localparam int LINE_COUNT  = 3;
    localparam int LINE_W      = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int PRICE_W     = 32;
    localparam int PERIOD_W    = 8;
    localparam int COUNT_W     = 9;
    localparam int RSI_W       = 14;
    localparam int AVG_W       = 60;
    localparam int SUM_W       = AVG_W + 1;
    localparam int PROD_W      = AVG_W + RSI_W;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DIGIT_W     = 4;

    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [AVG_W-1:0]   AVG_CAP     = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [RSI_W-1:0]   NEUTRAL_RSI = 14'd5000;
    localparam logic [RSI_W-1:0]   FULL_RSI    = 14'd10000;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET [LINE_COUNT] = '{8'd6, 8'd12, 8'd24};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_AVG_WAIT,
        ST_RSI,
        ST_RSI_WAIT,
        ST_NEXT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic start;
        logic wide;
    } div_cmd_t;

    // dividend width of the shared divider, a whole number of digits
    function automatic int num_width(int fraction_bits);
        int raw;
        raw = AVG_W + PERIOD_W + 1;
        if (AVG_W + fraction_bits > raw)
        begin
            raw = AVG_W + fraction_bits;
        end
        return ((raw + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    endfunction

endpackage

/* rtl/wrsi_if.sv */
interface wrsi_price_if;
    logic                         valid;
    logic                         ready;
    logic [wrsi_pkg::PRICE_W-1:0] close_price;
    logic                         restart;

    modport source (output valid, close_price, restart, input ready);
    modport sink (input valid, close_price, restart, output ready);
endinterface

interface wrsi_rsi_if;
    logic                       valid;
    logic                       ready;
    logic [wrsi_pkg::RSI_W-1:0] rsi_first;
    logic [wrsi_pkg::RSI_W-1:0] rsi_second;
    logic [wrsi_pkg::RSI_W-1:0] rsi_third;

    modport source (output valid, rsi_first, rsi_second, rsi_third, input ready);
    modport sink (input valid, rsi_first, rsi_second, rsi_third, output ready);
endinterface

/* rtl/wilder_rsi_three_period.sv */
// Three-line Wilder RSI. Each price transaction yields one result transaction carrying
// the RSI of three lines in hundredths of a percent (0..10000). A transaction with restart
// set, or the first one after reset, opens a new series and returns 5000 on every line.
// Any other transaction is worked through one line at a time on a single shared divider:
// per line two average updates (a 4-bit-per-cycle division by the period, NUM_W/4 steps,
// where NUM_W = 4*ceil(max(69, 60 + FRACTION_BITS)/4)) and one ratio division (one bit
// per cycle, 14 steps); a line still summing its warm-up skips those divisions. The price
// channel is ready only while the sequencer is idle; a finished result sits in an output
// register, so the next price is taken while that result waits. Periods are to be written
// on the cfg port while idle, a duty of the user that the block does not enforce; a
// period of zero acts as one.
module wilder_rsi_three_period #(
    parameter int FRACTION_BITS = wrsi_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [wrsi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wrsi_pkg::CFG_DATA_W-1:0]    cfg_data,
    wrsi_price_if.sink                         price_ch,
    wrsi_rsi_if.source                         rsi_ch
);

    localparam int NUM_W = wrsi_pkg::num_width(FRACTION_BITS);
    localparam int MUL_W = wrsi_pkg::AVG_W + wrsi_pkg::PERIOD_W;

    // sequencer
    wrsi_pkg::state_t state_reg;
    wrsi_pkg::state_t state_next;

    // configuration and series state
    logic [wrsi_pkg::PERIOD_W-1:0] period_reg [wrsi_pkg::LINE_COUNT];
    logic [wrsi_pkg::PRICE_W-1:0]  prev_close_reg;
    logic [wrsi_pkg::COUNT_W-1:0]  samples_reg;
    logic [wrsi_pkg::COUNT_W-1:0]  diff_count_reg;
    logic [wrsi_pkg::COUNT_W-1:0]  diff_count_next;
    logic [wrsi_pkg::COUNT_W-1:0]  samples_inc;
    logic [wrsi_pkg::PRICE_W-1:0]  up_reg;
    logic [wrsi_pkg::PRICE_W-1:0]  down_reg;
    logic [wrsi_pkg::AVG_W-1:0]    gain_reg [wrsi_pkg::LINE_COUNT];
    logic [wrsi_pkg::AVG_W-1:0]    loss_reg [wrsi_pkg::LINE_COUNT];

    // walk over lines, gain half then loss half
    logic [wrsi_pkg::LINE_W-1:0]   line_reg;
    logic                          half_reg;

    // results under construction and the output register
    logic [wrsi_pkg::RSI_W-1:0]    rsi_reg [wrsi_pkg::LINE_COUNT];
    logic [wrsi_pkg::RSI_W-1:0]    out_rsi_reg [wrsi_pkg::LINE_COUNT];
    logic                          out_valid_reg;

    logic                          price_acc;
    logic                          rsi_acc;
    logic                          out_free;
    logic                          new_series;

    // per-line operands
    logic [wrsi_pkg::PERIOD_W-1:0] period_cur;
    logic [wrsi_pkg::PERIOD_W-1:0] p_cur;
    logic [wrsi_pkg::AVG_W-1:0]    avg_cur;
    logic [wrsi_pkg::PRICE_W-1:0]  x_cur;
    logic [wrsi_pkg::SUM_W-1:0]    add_full;
    logic [wrsi_pkg::AVG_W-1:0]    add_sat;
    logic                          warm;
    logic                          at_period;
    logic                          rsi_live;
    logic [MUL_W-1:0]              smooth_prod;
    logic [NUM_W-1:0]              avg_num;
    logic [wrsi_pkg::AVG_W-1:0]    gain_cur;
    logic [wrsi_pkg::AVG_W-1:0]    loss_cur;
    logic [wrsi_pkg::SUM_W-1:0]    gl_sum;
    logic [wrsi_pkg::PROD_W-1:0]   gain_scaled;

    // shared divider
    wrsi_pkg::div_cmd_t            div_cmd;
    logic [NUM_W-1:0]              div_num;
    logic [wrsi_pkg::SUM_W-1:0]    div_rem;
    logic [wrsi_pkg::SUM_W-1:0]    div_den;
    logic                          div_done;
    logic [NUM_W-1:0]              div_quo;
    logic [wrsi_pkg::AVG_W-1:0]    quo_sat;

    // sequencer outputs
    logic                          avg_wr;
    logic [wrsi_pkg::AVG_W-1:0]    avg_wr_data;
    logic                          rsi_wr;
    logic [wrsi_pkg::RSI_W-1:0]    rsi_wr_data;
    logic                          line_adv;
    logic                          out_load;

    // handshakes
    assign price_ch.ready = (state_reg == wrsi_pkg::ST_IDLE);
    assign price_acc      = price_ch.valid && price_ch.ready;
    assign rsi_acc        = rsi_ch.valid && rsi_ch.ready;
    assign out_free       = !out_valid_reg || rsi_ch.ready;
    assign new_series     = price_ch.restart || (samples_reg == '0);

    assign rsi_ch.valid      = out_valid_reg;
    assign rsi_ch.rsi_first  = out_rsi_reg[0];
    assign rsi_ch.rsi_second = out_rsi_reg[1];
    assign rsi_ch.rsi_third  = out_rsi_reg[2];

    // difference count, saturating with the sample count
    always_comb
    begin
        samples_inc     = (samples_reg == wrsi_pkg::COUNT_MAX) ? samples_reg
                                                               : samples_reg + 1'b1;
        diff_count_next = samples_inc - 1'b1;
    end

    // operands of the current line and half
    always_comb
    begin
        period_cur = period_reg[line_reg];
        p_cur      = (period_cur == '0) ? wrsi_pkg::PERIOD_W'(1) : period_cur;
        avg_cur    = half_reg ? loss_reg[line_reg] : gain_reg[line_reg];
        x_cur      = half_reg ? down_reg : up_reg;

        // warm-up: plain running sum of ticks, capped
        add_full   = wrsi_pkg::SUM_W'(avg_cur) + wrsi_pkg::SUM_W'(x_cur);
        add_sat    = (add_full > wrsi_pkg::SUM_W'(wrsi_pkg::AVG_CAP)) ? wrsi_pkg::AVG_CAP
                                                                      : add_full[wrsi_pkg::AVG_W-1:0];
        warm       = (diff_count_reg <= wrsi_pkg::COUNT_W'(p_cur));
        at_period  = (diff_count_reg == wrsi_pkg::COUNT_W'(p_cur));
        rsi_live   = (diff_count_reg >= wrsi_pkg::COUNT_W'(p_cur));

        // smoothing numerator avg*(p-1) + x in fixed point
        smooth_prod = MUL_W'(avg_cur) * MUL_W'(p_cur - 1'b1);
        if (warm)
        begin
            avg_num = NUM_W'(add_sat) << FRACTION_BITS;
        end
        else
        begin
            avg_num = NUM_W'(smooth_prod) + (NUM_W'(x_cur) << FRACTION_BITS);
        end

        // ratio 10000*g/(g+l)
        gain_cur    = gain_reg[line_reg];
        loss_cur    = loss_reg[line_reg];
        gl_sum      = wrsi_pkg::SUM_W'(gain_cur) + wrsi_pkg::SUM_W'(loss_cur);
        gain_scaled = wrsi_pkg::PROD_W'(gain_cur) * wrsi_pkg::PROD_W'(wrsi_pkg::FULL_RSI);

        // quotient of an average update, capped
        quo_sat = (|div_quo[NUM_W-1:wrsi_pkg::AVG_W]) ? wrsi_pkg::AVG_CAP
                                                      : div_quo[wrsi_pkg::AVG_W-1:0];
    end

    // divider operands: narrow for averages, wide for the ratio
    always_comb
    begin
        if (div_cmd.wide)
        begin
            // quotient fits in 14 bits, so the upper part of the numerator seeds the remainder
            div_num = {gain_scaled[wrsi_pkg::RSI_W-1:0], (NUM_W - wrsi_pkg::RSI_W)'(0)};
            div_rem = wrsi_pkg::SUM_W'(gain_scaled[wrsi_pkg::PROD_W-1:wrsi_pkg::RSI_W]);
            div_den = gl_sum;
        end
        else
        begin
            div_num = avg_num;
            div_rem = '0;
            div_den = wrsi_pkg::SUM_W'(p_cur);
        end
    end

    wrsi_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .num      (div_num),
        .rem_init (div_rem),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo)
    );

    // next state and sequencer outputs
    always_comb
    begin
        state_next  = state_reg;
        div_cmd     = '0;
        avg_wr      = 1'b0;
        avg_wr_data = add_sat;
        rsi_wr      = 1'b0;
        rsi_wr_data = wrsi_pkg::NEUTRAL_RSI;
        line_adv    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
            begin
                if (price_acc)
                begin
                    state_next = new_series ? wrsi_pkg::ST_OUTPUT : wrsi_pkg::ST_AVG;
                end
            end
            wrsi_pkg::ST_AVG:
            begin
                if (warm && !at_period)
                begin
                    // still summing, no division
                    avg_wr     = 1'b1;
                    state_next = half_reg ? wrsi_pkg::ST_RSI : wrsi_pkg::ST_AVG;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    state_next    = wrsi_pkg::ST_AVG_WAIT;
                end
            end
            wrsi_pkg::ST_AVG_WAIT:
            begin
                avg_wr_data = quo_sat;
                if (div_done)
                begin
                    avg_wr     = 1'b1;
                    state_next = half_reg ? wrsi_pkg::ST_RSI : wrsi_pkg::ST_AVG;
                end
            end
            wrsi_pkg::ST_RSI:
            begin
                if (rsi_live && (loss_cur != '0))
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.wide  = 1'b1;
                    state_next    = wrsi_pkg::ST_RSI_WAIT;
                end
                else
                begin
                    // neutral during warm-up, full scale with no losses
                    rsi_wr      = 1'b1;
                    rsi_wr_data = rsi_live ? wrsi_pkg::FULL_RSI : wrsi_pkg::NEUTRAL_RSI;
                    state_next  = wrsi_pkg::ST_NEXT;
                end
            end
            wrsi_pkg::ST_RSI_WAIT:
            begin
                rsi_wr_data = div_quo[wrsi_pkg::RSI_W-1:0];
                if (div_done)
                begin
                    rsi_wr     = 1'b1;
                    state_next = wrsi_pkg::ST_NEXT;
                end
            end
            wrsi_pkg::ST_NEXT:
            begin
                if (line_reg == wrsi_pkg::LINE_W'(wrsi_pkg::LINE_COUNT - 1))
                begin
                    state_next = wrsi_pkg::ST_OUTPUT;
                end
                else
                begin
                    line_adv   = 1'b1;
                    state_next = wrsi_pkg::ST_AVG;
                end
            end
            wrsi_pkg::ST_OUTPUT:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = wrsi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wrsi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
            half_reg      <= 1'b0;
            for (int k = 0; k < wrsi_pkg::LINE_COUNT; k++)
            begin
                period_reg[k] <= wrsi_pkg::PERIOD_RESET[k];
            end
        end
        else
        begin
            if (cfg_wr_en && (cfg_index < wrsi_pkg::CFG_INDEX_W'(wrsi_pkg::LINE_COUNT)))
            begin
                period_reg[cfg_index[wrsi_pkg::LINE_W-1:0]] <= cfg_data;
            end
            if (price_acc)
            begin
                samples_reg <= new_series ? wrsi_pkg::COUNT_W'(1) : samples_inc;
                line_reg    <= '0;
                half_reg    <= 1'b0;
            end
            if (avg_wr)
            begin
                half_reg <= !half_reg;
            end
            if (line_adv)
            begin
                line_reg <= line_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsi_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // series data and results
    always_ff @(posedge clk)
    begin
        if (price_acc)
        begin
            prev_close_reg <= price_ch.close_price;
            if (new_series)
            begin
                for (int k = 0; k < wrsi_pkg::LINE_COUNT; k++)
                begin
                    gain_reg[k] <= '0;
                    loss_reg[k] <= '0;
                    rsi_reg[k]  <= wrsi_pkg::NEUTRAL_RSI;
                end
            end
            else
            begin
                diff_count_reg <= diff_count_next;
                if (price_ch.close_price >= prev_close_reg)
                begin
                    up_reg   <= price_ch.close_price - prev_close_reg;
                    down_reg <= '0;
                end
                else
                begin
                    up_reg   <= '0;
                    down_reg <= prev_close_reg - price_ch.close_price;
                end
            end
        end
        if (avg_wr)
        begin
            if (half_reg)
            begin
                loss_reg[line_reg] <= avg_wr_data;
            end
            else
            begin
                gain_reg[line_reg] <= avg_wr_data;
            end
        end
        if (rsi_wr)
        begin
            rsi_reg[line_reg] <= rsi_wr_data;
        end
        if (out_load)
        begin
            out_rsi_reg <= rsi_reg;
        end
    end

endmodule

/* rtl/wrsi_div.sv */
module wrsi_div #(
    parameter int NUM_W = wrsi_pkg::num_width(wrsi_pkg::DEF_FRACTION_BITS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrsi_pkg::div_cmd_t           cmd,
    input  logic [NUM_W-1:0]             num,
    input  logic [wrsi_pkg::SUM_W-1:0]   rem_init,
    input  logic [wrsi_pkg::SUM_W-1:0]   den,
    output logic                         done,
    output logic [NUM_W-1:0]             quo
);

    localparam int NARROW_STEPS = NUM_W / wrsi_pkg::DIGIT_W;
    localparam int MAX_STEPS    = (NARROW_STEPS > wrsi_pkg::RSI_W) ? NARROW_STEPS
                                                                   : wrsi_pkg::RSI_W;
    localparam int CNT_W        = $clog2(MAX_STEPS + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          wide_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [wrsi_pkg::SUM_W-1:0]    rem_reg;
    logic [wrsi_pkg::SUM_W-1:0]    den_reg;
    logic [NUM_W-1:0]              num_reg;

    logic [wrsi_pkg::DIGIT_W-1:0]  narrow_q;
    logic [wrsi_pkg::PERIOD_W-1:0] narrow_rem;
    logic [wrsi_pkg::SUM_W:0]      wide_trial;
    logic [wrsi_pkg::SUM_W:0]      wide_diff;
    logic                          wide_fit;
    logic [wrsi_pkg::SUM_W-1:0]    wide_rem;

    // four restoring steps on a remainder below an 8-bit divisor
    always_comb
    begin : narrow_step
        logic [wrsi_pkg::PERIOD_W:0]   trial;
        logic [wrsi_pkg::PERIOD_W-1:0] part;
        part     = rem_reg[wrsi_pkg::PERIOD_W-1:0];
        narrow_q = '0;
        for (int i = 0; i < wrsi_pkg::DIGIT_W; i++)
        begin
            trial = {part, num_reg[NUM_W-1-i]};
            if (trial >= {1'b0, den_reg[wrsi_pkg::PERIOD_W-1:0]})
            begin
                trial = trial - {1'b0, den_reg[wrsi_pkg::PERIOD_W-1:0]};
                narrow_q[wrsi_pkg::DIGIT_W-1-i] = 1'b1;
            end
            part = trial[wrsi_pkg::PERIOD_W-1:0];
        end
        narrow_rem = part;
    end

    // one restoring step on the full-width divisor
    always_comb
    begin
        wide_trial = {rem_reg, num_reg[NUM_W-1]};
        wide_diff  = wide_trial - {1'b0, den_reg};
        wide_fit   = (wide_trial >= {1'b0, den_reg});
        wide_rem   = wide_fit ? wide_diff[wrsi_pkg::SUM_W-1:0]
                              : wide_trial[wrsi_pkg::SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            wide_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                wide_reg <= cmd.wide;
                cnt_reg  <= cmd.wide ? CNT_W'(wrsi_pkg::RSI_W) : CNT_W'(NARROW_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            num_reg <= num;
            rem_reg <= cmd.wide ? rem_init : '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (wide_reg)
            begin
                rem_reg <= wide_rem;
                num_reg <= {num_reg[NUM_W-2:0], wide_fit};
            end
            else
            begin
                rem_reg <= wrsi_pkg::SUM_W'(narrow_rem);
                num_reg <= {num_reg[NUM_W-wrsi_pkg::DIGIT_W-1:0], narrow_q};
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

/* rtl/wrsi_checker.sv */
module wrsi_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         price_valid,
    input logic                         price_ready,
    input logic                         rsi_valid,
    input logic                         rsi_ready,
    input logic [wrsi_pkg::RSI_W-1:0]   rsi_first,
    input logic [wrsi_pkg::RSI_W-1:0]   rsi_second,
    input logic [wrsi_pkg::RSI_W-1:0]   rsi_third
);

    logic [1:0] pending_reg;
    logic       price_acc;
    logic       rsi_acc;

    assign price_acc = price_valid && price_ready;
    assign rsi_acc   = rsi_valid && rsi_ready;

    // transactions taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (price_acc && !rsi_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (rsi_acc && !price_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // one price at a time through the sequencer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        price_acc |=> !price_ready)
        else $error("price channel ready right after a transaction");

    // no result without a price behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsi_valid |-> (pending_reg != 2'd0))
        else $error("result offered with no price outstanding");

    // at most one in work and one waiting in the output register
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        price_acc |-> (pending_reg <= 2'd1))
        else $error("price taken with two transactions outstanding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsi_valid && !rsi_ready) |=> (rsi_valid && $stable(rsi_first)
                                       && $stable(rsi_second) && $stable(rsi_third)))
        else $error("stalled result dropped or changed");

endmodule

bind wilder_rsi_three_period wrsi_checker u_wrsi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .price_valid (price_ch.valid),
    .price_ready (price_ch.ready),
    .rsi_valid   (rsi_ch.valid),
    .rsi_ready   (rsi_ch.ready),
    .rsi_first   (rsi_ch.rsi_first),
    .rsi_second  (rsi_ch.rsi_second),
    .rsi_third   (rsi_ch.rsi_third)
);
